>>> src/ptta_pkg.sv
// shared types, constants and angle table of the path to trajectory annotator
package ptta_pkg;

  // default number of cordic iterations
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  // entries in the arctangent table
  localparam int unsigned ANG_TAB_LEN      = 24;
  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;
  localparam logic [33:0] INV_GAIN_Q30 = 34'd652032874;
  localparam logic [26:0] TWO_PI_Q24   = 27'd105414357;
  localparam logic [15:0] VEL_RESET    = 16'd256;

  // input request
  typedef struct packed {
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic               last_point;
  } in_req_t;

  // output request
  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [15:0] heading_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic        [31:0] time_offset;
    logic        [15:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic               last_out;
  } out_req_t;

  // kind of queued command
  typedef enum logic {
    CMD_SINGLE,
    CMD_STEP
  } cmd_e;

  // command handed from front to back
  typedef struct packed {
    cmd_e        kind;
    logic        first;
    logic        last;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] px;
    logic [31:0] py;
  } cmd_t;

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [29:0] ang_tab(input int unsigned idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ptta_front.sv
// front end: accepts path points, tracks path phase and queues commands
module ptta_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ptta_pkg::in_req_t in_req_i,
  input  logic            full_i,
  output logic            push_o,
  output ptta_pkg::cmd_t  push_cmd_o
);
  import ptta_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_HOLD,
    PH_PATH
  } phase_e;

  phase_e      phase_q;
  logic [31:0] px_q, py_q;
  logic        accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // build the command for the back end
  always_comb begin
    push_o           = accept & ((phase_q != PH_FIRST) | in_req_i.last_point);
    push_cmd_o.kind  = (phase_q == PH_FIRST) ? CMD_SINGLE : CMD_STEP;
    push_cmd_o.first = (phase_q == PH_HOLD);
    push_cmd_o.last  = in_req_i.last_point;
    push_cmd_o.x     = in_req_i.x_pos;
    push_cmd_o.y     = in_req_i.y_pos;
    push_cmd_o.px    = (phase_q == PH_FIRST) ? in_req_i.x_pos : px_q;
    push_cmd_o.py    = (phase_q == PH_FIRST) ? in_req_i.y_pos : py_q;
  end

  // phase and previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      px_q    <= '0;
      py_q    <= '0;
    end else if (accept) begin
      px_q <= in_req_i.x_pos;
      py_q <= in_req_i.y_pos;
      unique case (phase_q)
        PH_FIRST: phase_q <= in_req_i.last_point ? PH_FIRST : PH_HOLD;
        PH_HOLD,
        PH_PATH:  phase_q <= in_req_i.last_point ? PH_FIRST : PH_PATH;
        default:  phase_q <= PH_FIRST;
      endcase
    end
  end

endmodule

>>> src/ptta_fifo.sv
// short command queue between front and back end
module ptta_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptta_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output ptta_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import ptta_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> src/ptta_back.sv
// back end: cordic, multipliers, serial dividers and output register
module ptta_back #(
  parameter int unsigned CORDIC_STEPS = ptta_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        velocity_i,
  input  ptta_pkg::cmd_t     cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptta_pkg::out_req_t out_req_o
);
  import ptta_pkg::*;

  localparam int unsigned IW = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC,
    ST_LEN,
    ST_SC_INIT,
    ST_SC,
    ST_MUL1,
    ST_MUL2,
    ST_DINIT,
    ST_DIV,
    ST_OUT1,
    ST_OUT2
  } state_e;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [IW-1:0]      it_q;
  logic signed [43:0] vx_q, vy_q;
  logic signed [33:0] va_q;
  logic signed [33:0] sx_q, sy_q, sa_q;
  logic [34:0]        ds_q;
  logic [15:0]        head_q, prev_head_q, dh_q;
  logic [47:0]        path_q, lensum_q;
  logic [15:0]        qz_q, qw_q;
  logic [58:0]        prod_q;
  logic [55:0]        tn_q, tq_q, yn_q, yq_q;
  logic [15:0]        tr_q;
  logic [34:0]        yr_q;
  logic [5:0]         dcnt_q;
  logic               ovalid_q;
  out_req_t           oreq_q;

  // difference and pre-rotation of a new step
  logic signed [32:0] dx, dy;
  logic signed [43:0] ex, ey, rx, ry;
  logic signed [33:0] ra;
  always_comb begin
    dx = $signed({cmd_i.x[31], cmd_i.x}) - $signed({cmd_i.px[31], cmd_i.px});
    dy = $signed({cmd_i.y[31], cmd_i.y}) - $signed({cmd_i.py[31], cmd_i.py});
    ex = {{11{dx[32]}}, dx};
    ey = {{11{dy[32]}}, dy};
    if (dx < 0) begin
      if (dy >= 0) begin
        rx = ey;
        ry = -ex;
        ra = 34'sd1073741824;
      end else begin
        rx = -ey;
        ry = ex;
        ra = -34'sd1073741824;
      end
    end else begin
      rx = ex;
      ry = ey;
      ra = '0;
    end
  end

  // one cordic micro-rotation for both modes
  logic signed [33:0] tab;
  logic signed [43:0] vxs, vys;
  logic signed [33:0] sxs, sys;
  always_comb begin
    tab = $signed({4'b0, ang_tab(32'(it_q))});
    vxs = vx_q >>> it_q;
    vys = vy_q >>> it_q;
    sxs = sx_q >>> it_q;
    sys = sy_q >>> it_q;
  end

  // length scaling by the inverse gain
  logic [62:0] lenp;
  assign lenp = 63'(vx_q[42:0]) * 63'(INV_GAIN_Q20) + (63'd1 << 27);

  // rounding of sine and cosine to q1.15
  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [18:0] r;
    t = v + 34'sd16384;
    r = t[33:15];
    if (r > 19'sd32767) begin
      return 16'h7fff;
    end else if (r < -19'sd32768) begin
      return 16'h8000;
    end
    return r[15:0];
  endfunction

  // heading difference magnitude and saturated path length
  logic [15:0] dh_new, dmag;
  logic [48:0] sum49;
  always_comb begin
    dh_new = cmd_q.first ? 16'd0 : head_q - prev_head_q;
    dmag   = dh_new[15] ? 16'(~dh_new + 16'd1) : dh_new;
    sum49  = {1'b0, path_q} + 49'(ds_q);
  end

  // restoring divider trial steps
  logic [16:0] ttr;
  logic [35:0] ytr;
  logic        tge, yge;
  always_comb begin
    ttr = {tr_q, tn_q[55]};
    ytr = {yr_q, yn_q[55]};
    tge = (ttr >= {1'b0, velocity_i});
    yge = (ytr >= {1'b0, ds_q});
  end

  // result fields of the point in hand
  logic [31:0] time_f;
  logic [15:0] ang_f, lin_f;
  always_comb begin
    if (velocity_i == '0) begin
      time_f = (lensum_q != '0) ? 32'hffff_ffff : 32'd0;
    end else begin
      time_f = (|tq_q[55:32]) ? 32'hffff_ffff : tq_q[31:0];
    end
    if (cmd_q.last || dh_q == '0) begin
      ang_f = '0;
    end else if (ds_q == '0) begin
      ang_f = dh_q[15] ? 16'h8000 : 16'h7fff;
    end else if (!dh_q[15]) begin
      ang_f = (yq_q > 56'd32767) ? 16'h7fff : yq_q[15:0];
    end else begin
      ang_f = (yq_q > 56'd32768) ? 16'h8000 : 16'(~yq_q[15:0] + 16'd1);
    end
    lin_f = cmd_q.last ? 16'd0 : velocity_i;
  end

  logic load;
  assign load        = ((state_q == ST_OUT1) || (state_q == ST_OUT2)) &&
                       (!ovalid_q || !out_stall_i);
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = ovalid_q;
  assign out_req_o   = oreq_q;

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovalid_q    <= 1'b0;
      prev_head_q <= '0;
      path_q      <= '0;
    end else begin
      if (!load && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            cmd_q  <= cmd_i;
            head_q <= '0;
            ds_q   <= '0;
            vx_q   <= rx <<< 8;
            vy_q   <= ry <<< 8;
            va_q   <= ra;
            it_q   <= '0;
            if (cmd_i.kind == CMD_SINGLE || (dx == 0 && dy == 0)) begin
              state_q <= ST_SC_INIT;
            end else begin
              state_q <= ST_VEC;
            end
          end
        end
        ST_VEC: begin
          if (vy_q >= 0) begin
            vx_q <= vx_q + vys;
            vy_q <= vy_q - vxs;
            va_q <= va_q + tab;
          end else begin
            vx_q <= vx_q - vys;
            vy_q <= vy_q + vxs;
            va_q <= va_q - tab;
          end
          it_q <= it_q + 1'b1;
          if (it_q == IW'(CORDIC_STEPS - 1)) begin
            state_q <= ST_LEN;
          end
        end
        ST_LEN: begin
          ds_q    <= lenp[62:28];
          head_q  <= 16'((va_q + 34'sd32768) >>> 16);
          state_q <= ST_SC_INIT;
        end
        ST_SC_INIT: begin
          sx_q    <= $signed(INV_GAIN_Q30);
          sy_q    <= '0;
          sa_q    <= $signed({{3{head_q[15]}}, head_q, 15'b0});
          it_q    <= '0;
          state_q <= ST_SC;
        end
        ST_SC: begin
          if (sa_q >= 0) begin
            sx_q <= sx_q - sys;
            sy_q <= sy_q + sxs;
            sa_q <= sa_q - tab;
          end else begin
            sx_q <= sx_q + sys;
            sy_q <= sy_q - sxs;
            sa_q <= sa_q + tab;
          end
          it_q <= it_q + 1'b1;
          if (it_q == IW'(CORDIC_STEPS - 1)) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          qz_q     <= to_q15(sy_q);
          qw_q     <= to_q15(sx_q);
          dh_q     <= dh_new;
          prod_q   <= 59'(dmag * velocity_i);
          lensum_q <= sum49[48] ? 48'hffff_ffff_ffff : sum49[47:0];
          state_q  <= (cmd_q.kind == CMD_SINGLE) ? ST_OUT2 : ST_MUL2;
        end
        ST_MUL2: begin
          prod_q  <= 59'(prod_q[31:0]) * 59'(TWO_PI_Q24);
          state_q <= ST_DINIT;
        end
        ST_DINIT: begin
          tn_q    <= {lensum_q, 8'b0};
          yn_q    <= {21'b0, prod_q[58:24]};
          tr_q    <= '0;
          yr_q    <= '0;
          tq_q    <= '0;
          yq_q    <= '0;
          dcnt_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          tn_q   <= {tn_q[54:0], 1'b0};
          yn_q   <= {yn_q[54:0], 1'b0};
          tr_q   <= tge ? 16'(ttr - {1'b0, velocity_i}) : ttr[15:0];
          yr_q   <= yge ? 35'(ytr - {1'b0, ds_q}) : ytr[34:0];
          tq_q   <= {tq_q[54:0], tge};
          yq_q   <= {yq_q[54:0], yge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 6'd55) begin
            state_q <= cmd_q.first ? ST_OUT1 : ST_OUT2;
          end
        end
        ST_OUT1: begin
          if (load) begin
            ovalid_q             <= 1'b1;
            oreq_q.x_out         <= cmd_q.px;
            oreq_q.y_out         <= cmd_q.py;
            oreq_q.heading_angle <= head_q;
            oreq_q.quat_z        <= qz_q;
            oreq_q.quat_w        <= qw_q;
            oreq_q.time_offset   <= '0;
            oreq_q.linear_speed  <= velocity_i;
            oreq_q.angular_speed <= '0;
            oreq_q.last_out      <= 1'b0;
            state_q              <= ST_OUT2;
          end
        end
        ST_OUT2: begin
          if (load) begin
            ovalid_q             <= 1'b1;
            oreq_q.x_out         <= cmd_q.x;
            oreq_q.y_out         <= cmd_q.y;
            oreq_q.heading_angle <= head_q;
            oreq_q.quat_z        <= qz_q;
            oreq_q.quat_w        <= qw_q;
            oreq_q.last_out      <= cmd_q.last;
            if (cmd_q.kind == CMD_SINGLE) begin
              oreq_q.time_offset   <= '0;
              oreq_q.linear_speed  <= '0;
              oreq_q.angular_speed <= '0;
              path_q               <= '0;
            end else begin
              oreq_q.time_offset   <= time_f;
              oreq_q.linear_speed  <= lin_f;
              oreq_q.angular_speed <= ang_f;
              path_q               <= cmd_q.last ? 48'd0 : lensum_q;
              prev_head_q          <= head_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/path_to_trajectory_annotator.sv
// top level of the path to trajectory annotator
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------
//   in       | input     | in_valid_i / in_stall_o | in_req_i  (in_req_t)
//   out      | output    | out_valid_o/ out_stall_i| out_req_o (out_req_t)
//   config   | input     | cfg_we_i               | cfg_wdata_i (velocity)
//
// a step runs through two cordic passes and a divider pair in the back end, and the
// held first point goes out with it when the step is the first of its path.
// a coincident step skips vectoring, a single-point path skips vectoring and the dividers.
// the first point of a longer path produces nothing until the second arrives.
// reset clears the path phase, velocity returns to 256 (1.0 m/s).
// a two-entry queue lets the front take points while the back or output stalls.
module path_to_trajectory_annotator #(
  parameter int unsigned CORDIC_STEPS = ptta_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptta_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptta_pkg::out_req_t out_req_o
);
  import ptta_pkg::*;

  logic [15:0] velocity_q;
  logic        push, pop, full, empty;
  cmd_t        push_cmd, head_cmd;

  // velocity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      velocity_q <= VEL_RESET;
    end else if (cfg_we_i) begin
      velocity_q <= cfg_wdata_i;
    end
  end

  ptta_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ptta_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .full_o     (full),
    .empty_o    (empty)
  );

  ptta_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .velocity_i  (velocity_q),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
